@@ src/twmf_pkg.sv @@
// Shared constants, payload types and controller/datapath interface types.
package twmf_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 16;
  localparam int TIME_W  = 32;
  localparam int TOTAL_W = VAL_W + $clog2(DEPTH);
  localparam int ENTRY_W = TIME_W + VAL_W;
  localparam int QUO_W   = VAL_W;
  localparam int STEP_W  = $clog2(QUO_W);

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000000;

  typedef struct packed {
    logic [VAL_W-1:0]  sample_value;
    logic [TIME_W-1:0] sample_time;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] mean_value;
    logic [CNT_W-1:0] held_count;
    logic             overflowed;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_oldest;
    logic drop;
    logic set_over;
    logic append;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic full;
    logic expired;
    logic out_free;
  } status_t;

endpackage

@@ src/twmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module twmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/twmf_ctrl.sv @@
// Controller state machine: expiry loop, append, serial divide and result hand-off.
module twmf_ctrl
  import twmf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_APPEND,
    S_DINIT,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.count_zero ? S_APPEND : S_READ;
        end
      end
      S_READ: begin
        cmd.rd_oldest = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        if (status.expired) begin
          cmd.drop  = 1'b1;
          state_nxt = status.count_one ? S_APPEND : S_READ;
        end else begin
          // The oldest live sample is pushed out to make room.
          if (status.full) begin
            cmd.drop     = 1'b1;
            cmd.set_over = 1'b1;
          end
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ src/twmf_dp.sv @@
// Datapath: sample ring, running total, window register, divider and output register.
module twmf_dp
  import twmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  in_t               in_data,
  input  logic              cfg_valid,
  input  logic [TIME_W-1:0] cfg_data,
  input  logic              out_stall,
  output logic              out_valid,
  output out_t              out_data,
  input  cmd_t              cmd,
  output status_t           status
);

  logic [TIME_W-1:0]  window_r;
  logic [IDX_W-1:0]   oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  in_t                sample_r;
  logic               over_r;
  logic [CNT_W-1:0]   rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic               out_valid_r;
  out_t               out_r;

  logic [ENTRY_W-1:0] rd_entry;
  logic [VAL_W-1:0]   rd_value;
  logic [TIME_W-1:0]  rd_time;
  logic [TIME_W-1:0]  age;
  logic [CNT_W:0]     slot_sum;
  logic [IDX_W-1:0]   slot;
  logic [CNT_W:0]     rem_sh;
  logic               q_bit;
  logic [CNT_W:0]     rem_diff;

  twmf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.append),
    .waddr(slot),
    .wdata({sample_r.sample_time, sample_r.sample_value}),
    .re   (cmd.rd_oldest),
    .raddr(oldest_r),
    .rdata(rd_entry)
  );

  assign rd_value = rd_entry[VAL_W-1:0];
  assign rd_time  = rd_entry[ENTRY_W-1:VAL_W];
  // Modular age; wrap of the timestamp counter is harmless.
  assign age      = sample_r.sample_time - rd_time;

  assign slot_sum = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(count_r);
  assign slot     = (slot_sum >= (CNT_W+1)'(DEPTH)) ?
                    IDX_W'(slot_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(slot_sum);

  assign rem_sh   = {rem_r, quo_r[QUO_W-1]};
  assign rem_diff = rem_sh - (CNT_W+1)'(count_r);
  assign q_bit    = (rem_sh >= (CNT_W+1)'(count_r));

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    if (cmd.drop) begin
      oldest_nxt = (oldest_r == IDX_W'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
      count_nxt  = count_r - 1'b1;
      total_nxt  = total_r - TOTAL_W'(rd_value);
    end else if (cmd.append) begin
      count_nxt = count_r + 1'b1;
      total_nxt = total_r + TOTAL_W'(sample_r.sample_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      oldest_r    <= '0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_data;
      over_r   <= 1'b0;
    end else if (cmd.set_over) begin
      over_r <= 1'b1;
    end
    // The mean fits in QUO_W bits, so the bits above them start out below count.
    if (cmd.div_init) begin
      rem_r <= CNT_W'(total_r[TOTAL_W-1:QUO_W]);
      quo_r <= total_r[QUO_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? CNT_W'(rem_diff) : CNT_W'(rem_sh);
      quo_r <= {quo_r[QUO_W-2:0], q_bit};
    end
    if (cmd.load_out) begin
      out_r.mean_value <= quo_r;
      out_r.held_count <= count_r;
      out_r.overflowed <= over_r;
    end
  end

  assign status.count_zero = (count_r == '0);
  assign status.count_one  = (count_r == CNT_W'(1));
  assign status.full       = (count_r == CNT_W'(DEPTH));
  assign status.expired    = (age > window_r);
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above store depth");
  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |-> count_r != '0)
    else $error("drop from an empty store");
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> count_r != CNT_W'(DEPTH))
    else $error("append into a full store");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("result overwrites a beat still waiting");
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> total_r == '0)
    else $error("running total not zero with an empty store");
`endif

endmodule

@@ src/time_window_mean_filter_unit.sv @@
// Top level of the time-window mean filter.
// Each input beat carries an unsigned Q3.13 sample and a 32-bit timestamp.
// Held samples older than the window register (modular age, strictly
// greater) are dropped from the front, the new sample is appended to a
// 64-entry ring, and one result beat gives the truncated mean, the held
// count and an overflow flag set when a live sample had to be pushed out of
// a full ring. One item is in work at a time. Held entries are examined
// from the oldest; each is fetched through the ring memory's registered
// read and then evaluated, and expired ones are dropped until a live one
// is found or the ring empties. An empty ring is not examined. The new
// sample is then appended, and the divider retires one quotient bit per
// cycle; the result then goes to the result register once it is free. A new
// input beat is taken while the previous result still waits at the output.
// The window register resets to 1000000 ticks and may be written through
// the configuration port while the block is idle.
module time_window_mean_filter_unit
  import twmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TIME_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  twmf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  twmf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_valid(cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

@@ tb/time_window_mean_filter_unit_tb.sv @@
// Self-checking testbench for the time-window mean filter unit.
module time_window_mean_filter_unit_tb
  import twmf_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 260;
  localparam int DRAIN_CYCLES = 200;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [TIME_W-1:0] window;
    in_t               item;
    logic              typed;
    out_t              want;
  } drill_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TIME_W-1:0] cfg_data;

  // Shadow copy of the sample ring and the window register.
  logic [VAL_W-1:0]   ring_value [DEPTH];
  logic [TIME_W-1:0]  ring_time [DEPTH];
  int unsigned        ring_head;
  int unsigned        ring_fill;
  logic [TOTAL_W-1:0] ring_sum;
  logic [TIME_W-1:0]  window_now;

  out_t mean_expected [$];
  int   mismatch_count;
  int   results_seen;
  bit   sender_quiet;
  bit   receiver_quiet;

  drill_row_t drill_table [15] = '{
    '{ROW_SAMPLE, 32'd0, '{16'hFFFF, 32'd0},          1'b1, '{16'hFFFF, 7'd1, 1'b0}},
    '{ROW_SAMPLE, 32'd0, '{16'h0000, 32'd10},         1'b1, '{16'h7FFF, 7'd2, 1'b0}},
    '{ROW_SAMPLE, 32'd0, '{16'hFFFF, 32'd20},         1'b1, '{16'hAAAA, 7'd3, 1'b0}},
    '{ROW_SAMPLE, 32'd0, '{16'h0000, 32'd1000020},    1'b0, '0},
    '{ROW_SAMPLE, 32'd0, '{16'h1234, 32'd5},          1'b1, '{16'h1234, 7'd1, 1'b0}},
    '{ROW_SAMPLE, 32'd0, '{16'h0001, 32'hFFFFFFF0},   1'b1, '{16'h0001, 7'd1, 1'b0}},
    '{ROW_SAMPLE, 32'd0, '{16'h0003, 32'h00000010},   1'b0, '0},
    '{ROW_WINDOW, 32'd0, '0,                          1'b0, '0},
    '{ROW_SAMPLE, 32'd0, '{16'h8000, 32'h00000010},   1'b0, '0},
    '{ROW_SAMPLE, 32'd0, '{16'h7FFF, 32'h00000011},   1'b1, '{16'h7FFF, 7'd1, 1'b0}},
    '{ROW_WINDOW, 32'hFFFFFFFF, '0,                   1'b0, '0},
    '{ROW_SAMPLE, 32'd0, '{16'h5555, 32'hAAAAAAAA},   1'b0, '0},
    '{ROW_SAMPLE, 32'd0, '{16'hAAAA, 32'h55555555},   1'b0, '0},
    '{ROW_WINDOW, WINDOW_RESET, '0,                   1'b0, '0},
    '{ROW_SAMPLE, 32'd0, '{16'h0000, 32'hFFFFFFFF},   1'b0, '0}
  };

  time_window_mean_filter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void drop_oldest_sample();
    ring_sum  = ring_sum - TOTAL_W'(ring_value[ring_head]);
    ring_head = (ring_head + 1 >= DEPTH) ? 0 : ring_head + 1;
    ring_fill = ring_fill - 1;
  endfunction

  // Expire old samples, append the new one and return the resulting mean.
  function automatic out_t window_mean_next(in_t s);
    out_t              r;
    logic [TIME_W-1:0] age;
    int unsigned       slot;
    bit                expiring;
    r.overflowed = 1'b0;
    expiring = 1'b1;
    while (expiring && ring_fill > 0) begin
      age = s.sample_time - ring_time[ring_head];
      if (age > window_now) drop_oldest_sample();
      else expiring = 1'b0;
    end
    if (ring_fill >= DEPTH) begin
      drop_oldest_sample();
      r.overflowed = 1'b1;
    end
    slot = ring_head + ring_fill;
    if (slot >= DEPTH) slot = slot - DEPTH;
    ring_value[slot] = s.sample_value;
    ring_time[slot]  = s.sample_time;
    ring_fill = ring_fill + 1;
    ring_sum  = ring_sum + TOTAL_W'(s.sample_value);
    r.mean_value = VAL_W'(ring_sum / TOTAL_W'(ring_fill));
    r.held_count = CNT_W'(ring_fill);
    return r;
  endfunction

  // Entered just after a rising edge; returns at the edge that took the beat.
  task automatic send_sample(in_t item, logic typed, out_t want);
    int   gap;
    out_t predicted;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = window_mean_next(item);
    mean_expected.insert(mean_expected.size(), typed ? want : predicted);
  endtask

  // The window is only rewritten once every result has been taken.
  task automatic set_window(logic [TIME_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (mean_expected.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    window_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result(out_t got);
    out_t want;
    results_seen++;
    if (mean_expected.size() == 0) begin
      $display("%0t unexpected result beat: mean %h count %0d overflow %b", $time,
               got.mean_value, got.held_count, got.overflowed);
      mismatch_count++;
    end else begin
      want = mean_expected.pop_front();
      if (got.mean_value !== want.mean_value) begin
        $display("%0t mean_value expected %h actual %h", $time,
                 want.mean_value, got.mean_value);
        mismatch_count++;
      end
      if (got.held_count !== want.held_count) begin
        $display("%0t held_count expected %0d actual %0d", $time,
                 want.held_count, got.held_count);
        mismatch_count++;
      end
      if (got.overflowed !== want.overflowed) begin
        $display("%0t overflowed expected %b actual %b", $time,
                 want.overflowed, got.overflowed);
        mismatch_count++;
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin : result_side
    int  wait_cycles;
    bit  held;
    out_stall = 1'b0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        wait_cycles = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        wait_cycles = receiver_quiet ? 0 : $urandom_range(0, 14);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result(out_data);
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("%0t no beat moved for %0d cycles", $time, IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [TIME_W-1:0] phase_window [6];
    logic [TIME_W-1:0] sample_clock;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] w;
    in_t               item;
    int                pick;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    mismatch_count = 0;
    results_seen   = 0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    ring_head      = 0;
    ring_fill      = 0;
    ring_sum       = '0;
    window_now     = WINDOW_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drill_table[i]) begin
      if (drill_table[i].kind == ROW_WINDOW)
        set_window(drill_table[i].window);
      else
        send_sample(drill_table[i].item, drill_table[i].typed, drill_table[i].want);
    end

    phase_window[0] = '0;
    phase_window[1] = 32'hFFFFFFFF;
    phase_window[2] = 32'd3000;
    phase_window[3] = 32'd150;
    phase_window[4] = WINDOW_RESET;
    phase_window[5] = $urandom();

    sample_clock = $urandom();
    span = 1;
    foreach (phase_window[p]) begin
      w = phase_window[p];
      set_window(w);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) begin
          sender_quiet   = ($urandom_range(0, 3) == 0);
          receiver_quiet = ($urandom_range(0, 3) == 0);
          // A dense span keeps the ring full; a sparse one holds only a few.
          span = ($urandom_range(0, 2) == 0) ? w / 8 : w / 96;
          if (span == 0) span = 1;
        end
        pick = $urandom_range(0, 39);
        if (pick == 0)
          sample_clock = $urandom();
        else if (pick == 1)
          sample_clock = sample_clock + w + 32'd1 + TIME_W'($urandom_range(0, 3));
        else
          sample_clock = sample_clock + TIME_W'($urandom_range(0, span));
        item.sample_time = sample_clock;
        if ($urandom_range(0, 7) == 0)
          item.sample_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
          item.sample_value = VAL_W'($urandom_range(0, 65535));
        send_sample(item, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (mean_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
src/twmf_pkg.sv
src/twmf_ram.sv
src/twmf_ctrl.sv
src/twmf_dp.sv
src/time_window_mean_filter_unit.sv
tb/time_window_mean_filter_unit_tb.sv
